>>> rtl/acs_pkg.sv
// Package: types and constants shared by the channel statistics block.
`default_nettype none
package acs_pkg;

  // Number of channels with their own statistics entry.
  localparam int unsigned CHANNELS = 2;
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [15:0] CLIP_RESET = 16'd32760;

  // One input word: a tagged PCM sample.
  typedef struct packed {
    logic               channel;
    logic signed [15:0] sample;
  } in_word_t;

  // Per-channel statistics; also the result word.
  typedef struct packed {
    logic        [31:0] sample_count;
    logic signed [47:0] sample_sum;
    logic        [62:0] square_sum;
    logic        [31:0] odd_count;
    logic        [31:0] clip_count;
    logic        [15:0] peak_magnitude;
    logic signed [15:0] smallest;
    logic signed [15:0] largest;
  } stat_word_t;

  localparam int unsigned STAT_W = $bits(stat_word_t);

  localparam stat_word_t STAT_RESET = '{
    sample_count:   32'd0,
    sample_sum:     48'sd0,
    square_sum:     63'd0,
    odd_count:      32'd0,
    clip_count:     32'd0,
    peak_magnitude: 16'd0,
    smallest:       16'sh7FFF,
    largest:        16'sh8000
  };

endpackage : acs_pkg
`default_nettype wire

>>> rtl/audio_channel_statistics.sv
// Top level: per-channel running statistics of tagged 16-bit PCM samples.
//
//  channel  direction  handshake               word
//  -------  ---------  ----------------------  ---------------------------------
//  in       input      in_valid_i / in_stall_o  in_word_i  (channel, sample)
//  out      output     out_valid_o / out_stall_i out_word_o (statistics of channel)
//  cfg      input      cfg_we_i                 cfg_wdata_i (clip threshold)
//
// Cycles: one word per cycle sustained while the output is not stalled. A
//   word accepted into the update stage has its result written to the output register when the output is free.
//   The pace is set by the statistics RAM: one read at accept, one
//   read-modify-write in the update stage.
// Reset: clears control state and the per-entry valid bits; an entry never
//   written reads as the reset statistics, so no clearing pass is needed.
// Stalls: out_stall_i holds the output register; the update stage then holds
//   and in_stall_o rises. A full output register still takes a new word
//   when the current one is taken in the same cycle.
`default_nettype none
module audio_channel_statistics
  import acs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // sample input
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire in_word_t   in_word_i,
  // statistics output
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      stat_word_t out_word_o,
  // clip threshold register
  input  wire logic       cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic [15:0] clip_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_thr_q <= CLIP_RESET;
    end else if (cfg_we_i) begin
      clip_thr_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------
  // Accept stage: magnitude, square and flags, RAM read issue
  // ---------------------------------------------------------------------
  logic                in_accept;
  logic                s1_go;
  logic                out_free;

  logic signed [16:0]  smp_ext;
  logic [16:0]         mag_d;
  logic [33:0]         prod;
  logic [CH_IDX_W-1:0] in_idx;
  logic                in_drop;

  assign in_accept = in_valid_i && !in_stall_o;
  assign smp_ext   = 17'(in_word_i.sample);
  assign mag_d     = smp_ext[16] ? 17'(-smp_ext) : 17'(smp_ext);
  assign prod      = {17'b0, mag_d} * {17'b0, mag_d};   // at most 2^30
  assign in_idx    = CH_IDX_W'(in_word_i.channel);
  assign in_drop   = !(32'(in_word_i.channel) < CHANNELS);

  // Update stage registers
  logic                s1_valid_q;
  logic                s1_drop_q;
  logic [CH_IDX_W-1:0] s1_idx_q;
  logic signed [15:0]  s1_sample_q;
  logic [16:0]         s1_mag_q;
  logic [30:0]         s1_sq_q;
  logic                s1_clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_go) begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_drop_q   <= in_drop;
      s1_idx_q    <= in_idx;
      s1_sample_q <= in_word_i.sample;
      s1_mag_q    <= mag_d;
      s1_sq_q     <= prod[30:0];
      s1_clip_q   <= (mag_d >= {1'b0, clip_thr_q});
    end
  end

  // ---------------------------------------------------------------------
  // Statistics RAM
  // ---------------------------------------------------------------------
  logic             ram_we;
  stat_word_t       upd;
  logic [STAT_W-1:0] ram_rdata;

  acs_ram #(
    .WIDTH (STAT_W),
    .DEPTH (CHANNELS)
  ) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_idx_q),
    .wdata_i (upd),
    .re_i    (in_accept),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  // Entry valid bits: an unwritten entry reads as the reset statistics.
  logic [CHANNELS-1:0] entry_vld_q;

  // Last written entry, forwarded over the read-before-write RAM.
  logic                wb_valid_q;
  logic [CH_IDX_W-1:0] wb_idx_q;
  stat_word_t          wb_word_q;

  // ---------------------------------------------------------------------
  // Update stage: read-modify-write
  // ---------------------------------------------------------------------
  stat_word_t cur;
  logic       sat;

  assign out_free = !out_valid_o || !out_stall_i;
  assign s1_go    = !s1_valid_q || s1_drop_q || out_free;
  assign ram_we   = s1_valid_q && !s1_drop_q && out_free;
  assign in_stall_o = !s1_go;

  always_comb begin
    if (wb_valid_q && (wb_idx_q == s1_idx_q)) begin
      cur = wb_word_q;
    end else if (entry_vld_q[s1_idx_q]) begin
      cur = stat_word_t'(ram_rdata);
    end else begin
      cur = STAT_RESET;
    end

    sat = (cur.sample_count == '1);
    upd = cur;
    if (!sat) begin
      upd.sample_count = cur.sample_count + 32'd1;
      upd.sample_sum   = cur.sample_sum + 48'(s1_sample_q);
      upd.square_sum   = cur.square_sum + 63'(s1_sq_q);
      upd.odd_count    = cur.odd_count + 32'(s1_sample_q[0]);
      upd.clip_count   = cur.clip_count + 32'(s1_clip_q);
    end
    // peak, min and max keep tracking after saturation
    if ({1'b0, cur.peak_magnitude} < s1_mag_q) begin
      upd.peak_magnitude = s1_mag_q[15:0];
    end
    if (s1_sample_q < cur.smallest) begin
      upd.smallest = s1_sample_q;
    end
    if (s1_sample_q > cur.largest) begin
      upd.largest = s1_sample_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
      wb_valid_q  <= 1'b0;
    end else if (ram_we) begin
      entry_vld_q[s1_idx_q] <= 1'b1;
      wb_valid_q            <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      wb_idx_q  <= s1_idx_q;
      wb_word_q <= upd;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic       out_valid_q;
  stat_word_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= ram_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      out_word_q <= upd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTH
  // every result follows at least one counted or saturated sample
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.sample_count != 32'd0)
    else $error("result with zero sample count");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.smallest <= out_word_o.largest)
    else $error("smallest above largest");

  a_sub_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.clip_count <= out_word_o.sample_count) &&
                    (out_word_o.odd_count <= out_word_o.sample_count))
    else $error("sub-count exceeds sample count");

  a_write_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> out_valid_o && (out_word_o == wb_word_q))
    else $error("RAM write without matching result");
`endif

endmodule : audio_channel_statistics
`default_nettype wire

>>> rtl/acs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module acs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-before-write on an address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : acs_ram
`default_nettype wire

>>> dv/audio_channel_statistics_tb.sv
// Testbench for audio_channel_statistics: random stimulus checked against a local statistics model.
`timescale 1ns / 1ps
module audio_channel_statistics_tb;
  import acs_pkg::*;

  localparam int HOLD_CYCLES = 80;   // long receiver hold-off in the pressure phase
  localparam int PRINT_CAP   = 40;   // mismatch lines printed before going quiet

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_word_t   in_word   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  stat_word_t out_word;
  logic       cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;

  audio_channel_statistics dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Words waiting to be offered, and statistics words waiting to come out.
  in_word_t   sample_queue [$];
  stat_word_t pending_stats [$];

  // Local copy of the block's state: one statistics entry per channel plus the
  // clip threshold register.
  stat_word_t  channel_stats [CHANNELS];
  logic [15:0] clip_level = CLIP_RESET;

  // Traffic shaping, set per phase while the block is idle.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_request  = 1'b0;
  bit          hold_on       = 1'b0;

  int unsigned mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #400us;
    $display("Some tests failed");
    $finish;
  end

  // Long receiver hold-off, timed in its own process. Changes land on the
  // falling edge so the stall driver sees a settled value at the rising edge.
  initial begin
    wait (hold_request);
    @(negedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_on = 1'b0;
  end

  task automatic flag_error(string msg);
    if (mismatches < PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Advance one channel's running statistics by one sample and queue the
  // word the block should return for it.
  function automatic void update_channel_stats(in_word_t w);
    stat_word_t          s;
    logic signed [16:0]  value;
    logic        [16:0]  mag;
    if (w.channel >= CHANNELS) return;   // no such channel: dropped silently
    s     = channel_stats[w.channel];
    value = {w.sample[15], w.sample};
    mag   = value[16] ? 17'(-value) : 17'(value);   // -32768 gives 32768
    // Once the count is pinned at its top, the counts and sums freeze.
    if (s.sample_count != '1) begin
      s.sample_count = s.sample_count + 32'd1;
      s.sample_sum   = s.sample_sum + {{31{value[16]}}, value};
      s.square_sum   = s.square_sum + 63'(mag) * 63'(mag);
      s.odd_count    = s.odd_count + 32'(w.sample[0]);
      // threshold 0 clips everything, above 32768 clips nothing
      if (mag >= 17'(clip_level)) s.clip_count = s.clip_count + 32'd1;
    end
    // Peak, min and max keep tracking even when saturated.
    if (mag > 17'(s.peak_magnitude)) s.peak_magnitude = mag[15:0];
    if ($signed(w.sample) < $signed(s.smallest)) s.smallest = w.sample;
    if ($signed(w.sample) > $signed(s.largest))  s.largest  = w.sample;
    channel_stats[w.channel] = s;
    pending_stats.push_back(s);
  endfunction

  task automatic check_stats(stat_word_t got);
    stat_word_t want;
    string      bad;
    if (pending_stats.size() == 0) begin
      flag_error($sformatf("stats word with none expected: %h", got));
      return;
    end
    want = pending_stats.pop_front();
    bad  = "";
    if (got.sample_count   !== want.sample_count)   bad = {bad, " sample_count"};
    if (got.sample_sum     !== want.sample_sum)     bad = {bad, " sample_sum"};
    if (got.square_sum     !== want.square_sum)     bad = {bad, " square_sum"};
    if (got.odd_count      !== want.odd_count)      bad = {bad, " odd_count"};
    if (got.clip_count     !== want.clip_count)     bad = {bad, " clip_count"};
    if (got.peak_magnitude !== want.peak_magnitude) bad = {bad, " peak_magnitude"};
    if (got.smallest       !== want.smallest)       bad = {bad, " smallest"};
    if (got.largest        !== want.largest)        bad = {bad, " largest"};
    if (bad != "")
      flag_error($sformatf("bad field(s)%s: got %h want %h", bad, got, want));
  endtask

  // Sample driver. Predicts on every accepted word; a stalled word is held
  // as is, otherwise the next word goes out unless this cycle idles.
  always @(posedge clk) begin : drive_samples
    in_word_t next_word;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) update_channel_stats(in_word);
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = sample_queue.pop_front();
          in_word  <= next_word;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and stall driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_stats(out_word);
      out_stall <= hold_on || ($urandom_range(99) < stall_pct);
    end
  end

  task automatic queue_sample(logic ch, logic signed [15:0] value);
    in_word_t w;
    w.channel = ch;
    w.sample  = value;
    sample_queue.push_back(w);
  endtask

  // Mix of rail values, near-zero values, values around the current clip
  // threshold (either sign) and fully random words.
  function automatic logic signed [15:0] rand_sample();
    int unsigned pick;
    int          level;
    pick  = $urandom_range(9);
    level = int'(clip_level) + int'($urandom_range(2)) - 1;
    case (pick)
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'($urandom_range(8)) - 16'd4;
      3:       return $urandom_range(1) ? 16'(level) : 16'(-level);
      default: return 16'($urandom);
    endcase
  endfunction

  // Idle means: nothing left to offer, nothing on the input, nothing owed.
  task automatic drain();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || pending_stats.size() != 0);
  endtask

  task automatic write_clip_level(logic [15:0] level);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= level;
    @(posedge clk);
    cfg_we    <= 1'b0;
    clip_level = level;
  endtask

  task automatic run_phase(int n, int unsigned idle_pct, int unsigned hold_pct);
    @(negedge clk);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    repeat (n) queue_sample(1'($urandom_range(1)), rand_sample());
    drain();
  endtask

  initial begin
    foreach (channel_stats[c]) channel_stats[c] = STAT_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset threshold, back-to-back words. First word on each
    // channel starts from the reset entry; rails, +-1, odd/even, and
    // magnitudes just below, at and above the default threshold.
    queue_sample(1'b0, 16'sd0);
    queue_sample(1'b0, 16'sd32767);
    queue_sample(1'b0, -16'sd32768);
    queue_sample(1'b0, 16'sd1);
    queue_sample(1'b0, -16'sd1);
    queue_sample(1'b0, 16'sd32760);
    queue_sample(1'b0, 16'sd32759);
    queue_sample(1'b0, -16'sd32760);
    queue_sample(1'b0, -16'sd32759);
    queue_sample(1'b1, -16'sd32768);
    queue_sample(1'b1, 16'sd32767);
    queue_sample(1'b1, 16'sd0);
    queue_sample(1'b1, 16'sd32761);
    queue_sample(1'b1, -16'sd2);
    queue_sample(1'b1, 16'sd3);
    queue_sample(1'b1, 16'sd16384);
    queue_sample(1'b1, -16'sd16385);
    queue_sample(1'b0, 16'sd2);
    drain();

    // Threshold 0: every word clips. No idling.
    write_clip_level(16'd0);
    run_phase(100, 0, 0);

    // Threshold at full-scale magnitude: only -32768 clips. Sender idles.
    write_clip_level(16'd32768);
    run_phase(90, 45, 0);

    // Threshold beyond any magnitude: nothing clips. Receiver stalls.
    write_clip_level(16'hFFFF);
    run_phase(90, 0, 45);

    // Random threshold in 1..32767, both sides idling.
    write_clip_level(16'($urandom_range(1, 32767)));
    run_phase(90, 22, 22);

    // Pressure: sender streams while the receiver holds off for a long
    // stretch, so the pipe fills and the input stalls.
    write_clip_level(16'd1);
    hold_request = 1'b1;
    run_phase(80, 0, 0);

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
